>>> rtl/core/bias_pkg.sv
// Package for the bounded integer array stack.
// Holds the request and response word types, request and status codes,
// and the memory command type. No dependencies.
`default_nettype none

package bias_pkg;

    // Default number of words in the store.
    localparam int DEF_CAPACITY = 256;
    // Widest address the capacity range can need.
    localparam int MAX_AW = 16;

    // Request codes.
    localparam logic [2:0] REQ_SET    = 3'd0;
    localparam logic [2:0] REQ_GET    = 3'd1;
    localparam logic [2:0] REQ_PUSH   = 3'd2;
    localparam logic [2:0] REQ_POP    = 3'd3;
    localparam logic [2:0] REQ_FIND   = 3'd4;
    localparam logic [2:0] REQ_SORT   = 3'd5;
    localparam logic [2:0] REQ_RESIZE = 3'd6;

    // Status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADINDEX = 2'd1;
    localparam logic [1:0] ST_NOROOM   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [7:0]         index;
        logic signed [31:0] value;
        logic [8:0]         new_length;
    } req_word_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [7:0]         found_index;
        logic [8:0]         length;
    } rsp_word_t;

    // One access of the single-port word store: a write, or else a read.
    typedef struct packed {
        logic              wr_en;
        logic [MAX_AW-1:0] addr;
        logic [31:0]       wdata;
    } mem_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/bias_mem.sv
// Single-port word store with a registered read.
// Depends on bias_pkg for the memory command type.
`default_nettype none

module bias_mem #(
    parameter int DEPTH = bias_pkg::DEF_CAPACITY
) (
    input  wire                 clk,
    input  bias_pkg::mem_cmd_t  cmd,
    output logic [31:0]         rdata
);
    import bias_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [31:0] mem [DEPTH];

    // A write takes the port; otherwise the addressed word is read.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.addr[AW-1:0]] <= cmd.wdata;
        end
        else
        begin
            rdata <= mem[cmd.addr[AW-1:0]];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bias_ctrl.sv
// Request sequencer: walks the word store for every request and builds
// the response word. Depends on bias_pkg; drives one bias_mem port.
`default_nettype none

module bias_ctrl #(
    parameter int CAPACITY = bias_pkg::DEF_CAPACITY
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  bias_pkg::req_word_t req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output bias_pkg::rsp_word_t rsp,
    output bias_pkg::mem_cmd_t  cmd,
    input  wire [31:0]          rdata
);
    import bias_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam logic [CMPW-1:0] CAP_W = CMPW'(CAPACITY);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_GETW  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCMP  = 4'd4;
    localparam logic [3:0] S_ZERO  = 4'd5;
    localparam logic [3:0] S_SKEY  = 4'd6;
    localparam logic [3:0] S_SKEYW = 4'd7;
    localparam logic [3:0] S_SRD   = 4'd8;
    localparam logic [3:0] S_SCMP  = 4'd9;
    localparam logic [3:0] S_SPUT  = 4'd10;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [31:0]   key_reg, key_next;
    req_word_t     req_reg, req_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_word_t     rsp_reg, rsp_next;

    logic [CMPW-1:0] count_w, idx_w, nlen_w, i_w, len_w;
    logic [CW-1:0]   i_inc, nlen_c;
    logic            idx_ok;

    assign count_w = CMPW'(count_reg);
    assign idx_w   = CMPW'(req_reg.index);
    assign nlen_w  = CMPW'(req_reg.new_length);
    assign i_w     = CMPW'(i_reg);
    assign len_w   = CMPW'(count_next);
    assign i_inc   = i_reg + 1'b1;
    assign nlen_c  = nlen_w[CW-1:0];
    assign idx_ok  = idx_w < count_w;

    // A new word is taken only when idle and the response slot is free.
    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic       fin;
        logic [1:0] st;
        logic [31:0] rd;
        logic [7:0] fi;
        fin            = 1'b0;
        st             = ST_OK;
        rd             = '0;
        fi             = '0;
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        key_next       = key_reg;
        req_next       = req_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        cmd            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && !req_stall)
                begin
                    req_next   = req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (req_reg.req_type)
                    REQ_SET:
                    begin
                        fin = 1'b1;
                        if (idx_ok)
                        begin
                            cmd.wr_en = 1'b1;
                            cmd.addr  = MAX_AW'(idx_w[AW-1:0]);
                            cmd.wdata = req_reg.value;
                        end
                        else
                        begin
                            st = ST_BADINDEX;
                        end
                    end
                    REQ_GET:
                    begin
                        if (idx_ok)
                        begin
                            cmd.addr   = MAX_AW'(idx_w[AW-1:0]);
                            state_next = S_GETW;
                        end
                        else
                        begin
                            fin = 1'b1;
                            st  = ST_BADINDEX;
                        end
                    end
                    REQ_PUSH:
                    begin
                        fin = 1'b1;
                        if (count_w < CAP_W)
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.addr   = MAX_AW'(count_reg[AW-1:0]);
                            cmd.wdata  = req_reg.value;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            st = ST_NOROOM;
                        end
                    end
                    REQ_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                            cmd.addr   = MAX_AW'(count_next[AW-1:0]);
                            state_next = S_GETW;
                        end
                        else
                        begin
                            fin = 1'b1;
                            st  = ST_BADINDEX;
                        end
                    end
                    REQ_FIND:
                    begin
                        i_next = '0;
                        if (count_reg == '0)
                        begin
                            fin = 1'b1;
                            st  = ST_NOTFOUND;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                    REQ_SORT:
                    begin
                        i_next = CW'(1);
                        if (count_w <= CMPW'(1))
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            state_next = S_SKEY;
                        end
                    end
                    REQ_RESIZE:
                    begin
                        if (nlen_w > CAP_W)
                        begin
                            fin = 1'b1;
                            st  = ST_NOROOM;
                        end
                        else if (nlen_w <= count_w)
                        begin
                            fin        = 1'b1;
                            count_next = nlen_c;
                        end
                        else
                        begin
                            i_next     = count_reg;
                            state_next = S_ZERO;
                        end
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            // Read data from a get or a pop is back.
            S_GETW:
            begin
                fin = 1'b1;
                rd  = rdata;
            end
            // Linear search, one read and one compare per word.
            S_FRD:
            begin
                cmd.addr   = MAX_AW'(i_reg[AW-1:0]);
                state_next = S_FCMP;
            end
            S_FCMP:
            begin
                if (rdata == req_reg.value)
                begin
                    fin = 1'b1;
                    fi  = i_w[7:0];
                end
                else if (i_inc == count_reg)
                begin
                    fin = 1'b1;
                    st  = ST_NOTFOUND;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = S_FRD;
                end
            end
            // Zero-fill of the words a resize adds, one per cycle.
            S_ZERO:
            begin
                cmd.wr_en = 1'b1;
                cmd.addr  = MAX_AW'(i_reg[AW-1:0]);
                i_next    = i_inc;
                if (i_inc == nlen_c)
                begin
                    fin        = 1'b1;
                    count_next = nlen_c;
                end
            end
            // Insertion sort: fetch the key, then shift larger words up.
            S_SKEY:
            begin
                cmd.addr   = MAX_AW'(i_reg[AW-1:0]);
                state_next = S_SKEYW;
            end
            S_SKEYW:
            begin
                key_next   = rdata;
                j_next     = i_reg;
                state_next = S_SRD;
            end
            S_SRD:
            begin
                cmd.addr   = MAX_AW'(AW'(j_reg - 1'b1));
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                cmd.wr_en = 1'b1;
                cmd.addr  = MAX_AW'(j_reg[AW-1:0]);
                if ($signed(key_reg) < $signed(rdata))
                begin
                    cmd.wdata = rdata;
                    j_next    = j_reg - 1'b1;
                    state_next = (j_next == '0) ? S_SPUT : S_SRD;
                end
                else
                begin
                    cmd.wdata = key_reg;
                    i_next    = i_inc;
                    if (i_inc == count_reg)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SKEY;
                    end
                end
            end
            S_SPUT:
            begin
                cmd.wr_en = 1'b1;
                cmd.addr  = '0;
                cmd.wdata = key_reg;
                i_next    = i_inc;
                if (i_inc == count_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    state_next = S_SKEY;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Load the response register when the request completes.
        if (fin)
        begin
            state_next           = S_IDLE;
            rsp_valid_next       = 1'b1;
            rsp_next.status      = st;
            rsp_next.read_value  = rd;
            rsp_next.found_index = fi;
            rsp_next.length      = len_w[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        key_reg <= key_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/bounded_int_array_stack.sv
// Top level of the bounded integer array stack: sequencer plus word store.
// Depends on bias_pkg, bias_ctrl and bias_mem.
`default_nettype none

// The block keeps up to CAPACITY signed 32-bit words and a length, and
// answers each request word with one response word. The words sit in a
// single-port memory with a registered read, so every request is
// worked through by a sequencer one memory access per cycle, one request
// at a time. Find reads and compares the words in turn; resize zero-fills
// each added word. Sort is an insertion sort, quadratic in the length at
// worst. No clearing pass follows reset.

module bounded_int_array_stack #(
    parameter int CAPACITY = bias_pkg::DEF_CAPACITY
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  bias_pkg::req_word_t req,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output bias_pkg::rsp_word_t rsp
);
    import bias_pkg::*;

    mem_cmd_t    cmd;
    logic [31:0] rdata;

    bias_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cmd      (cmd),
        .rdata    (rdata)
    );

    bias_mem #(
        .DEPTH(CAPACITY)
    ) u_mem (
        .clk  (clk),
        .cmd  (cmd),
        .rdata(rdata)
    );

endmodule

`default_nettype wire

>>> rtl/core/bias_checker.sv
// Port-level checks for the bounded integer array stack, and their bind.
// Depends on bias_pkg and bounded_int_array_stack.
`default_nettype none

module bias_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 req_valid,
    input wire                 req_stall,
    input bias_pkg::req_word_t req,
    input wire                 rsp_valid,
    input wire                 rsp_stall,
    input bias_pkg::rsp_word_t rsp
);
    import bias_pkg::*;

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response word does not change.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("response word changed while stalled");

    // One request at a time: an accepted word blocks the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // A response only appears after a request has been in work.
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response without request");

endmodule

bind bounded_int_array_stack bias_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
);

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the bounded integer array stack.
// Depends on bias_pkg and bounded_int_array_stack; predicts every response word.
`default_nettype none

module testbench;
    import bias_pkg::*;

    localparam int CAP = DEF_CAPACITY;

    // Scoreboard: shadow array, expected responses and mismatch count.
    class stack_scoreboard;
        logic [31:0] shadow [CAP];
        int unsigned depth;
        rsp_word_t   pending [$];
        int          errors;

        function new();
            depth = 0;
            errors = 0;
            foreach (shadow[i]) shadow[i] = '0;
        endfunction

        // Apply one accepted request to the shadow state and queue its response.
        function void note_request(req_word_t r);
            rsp_word_t   e;
            logic [31:0] key;
            int          j;
            e = '0;
            e.status = ST_OK;
            case (r.req_type)
                REQ_SET:
                    if (r.index < depth) shadow[r.index] = r.value;
                    else e.status = ST_BADINDEX;
                REQ_GET:
                    if (r.index < depth) e.read_value = shadow[r.index];
                    else e.status = ST_BADINDEX;
                REQ_PUSH:
                    if (depth < CAP)
                    begin
                        shadow[depth] = r.value;
                        depth++;
                    end
                    else e.status = ST_NOROOM;
                REQ_POP:
                    if (depth > 0)
                    begin
                        depth--;
                        e.read_value = shadow[depth];
                    end
                    else e.status = ST_BADINDEX;
                REQ_FIND:
                begin
                    e.status = ST_NOTFOUND;
                    for (int i = 0; i < depth; i++)
                        if (shadow[i] == r.value)
                        begin
                            e.status = ST_OK;
                            e.found_index = i[7:0];
                            break;
                        end
                end
                REQ_SORT:
                    // Insertion sort on signed values.
                    for (int i = 1; i < depth; i++)
                    begin
                        key = shadow[i];
                        j = i;
                        while (j > 0 && $signed(key) < $signed(shadow[j-1]))
                        begin
                            shadow[j] = shadow[j-1];
                            j--;
                        end
                        shadow[j] = key;
                    end
                REQ_RESIZE:
                    if (r.new_length > CAP) e.status = ST_NOROOM;
                    else
                    begin
                        for (int i = depth; i < r.new_length; i++) shadow[i] = '0;
                        depth = r.new_length;
                    end
                default: ;
            endcase
            e.length = depth[8:0];
            pending.push_back(e);
        endfunction

        // Compare one accepted response with the oldest expectation.
        function void check_response(rsp_word_t a);
            rsp_word_t e;
            if (pending.size() == 0)
            begin
                $error("response with nothing expected: %h", a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, a.status);
                errors++;
            end
            if (a.read_value !== e.read_value)
            begin
                $error("read_value expected %0d actual %0d", e.read_value, a.read_value);
                errors++;
            end
            if (a.found_index !== e.found_index)
            begin
                $error("found_index expected %0d actual %0d", e.found_index, a.found_index);
                errors++;
            end
            if (a.length !== e.length)
            begin
                $error("length expected %0d actual %0d", e.length, a.length);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_word_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_word_t rsp;

    stack_scoreboard sb;
    bit          sending_done;
    bit          hold_rsp;
    int unsigned words_sent;

    bounded_int_array_stack u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Offer one request word and hold it until accepted, after a random gap.
    // Valid stays high after acceptance so that a word with no gap follows
    // directly; the caller drops it before any pause.
    task automatic send_request(req_word_t r, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(16);
        if ($urandom_range(3) == 0) gap = 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_request(r);
        words_sent++;
    endtask

    function automatic req_word_t make_req(logic [2:0] t, logic [7:0] idx,
                                           logic [31:0] v, logic [8:0] nl);
        req_word_t r;
        r.req_type = t;
        r.index = idx;
        r.value = v;
        r.new_length = nl;
        return r;
    endfunction

    // Random value, often from a small set so find and sort see duplicates.
    function automatic logic [31:0] rand_value();
        case ($urandom_range(4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(7) - 3;
            default: return $urandom;
        endcase
    endfunction

    // Random request weighted toward small lengths; large sizes only rarely.
    function automatic req_word_t rand_req(int unsigned cur);
        logic [2:0] t;
        logic [7:0] idx;
        logic [8:0] nl;
        int         p;
        p = $urandom_range(99);
        if (p < 22) t = REQ_SET;
        else if (p < 44) t = REQ_GET;
        else if (p < 62) t = REQ_PUSH;
        else if (p < 78) t = REQ_POP;
        else if (p < 88) t = REQ_FIND;
        else if (p < 92) t = REQ_SORT;
        else if (p < 98) t = REQ_RESIZE;
        else t = 3'd7;
        if (cur > 0 && $urandom_range(4) != 0) idx = 8'($urandom_range(cur - 1));
        else idx = 8'($urandom);
        if ($urandom_range(19) == 0) nl = $urandom_range(CAP + 2) > CAP ? 9'h1ff : 9'(CAP);
        else nl = 9'($urandom_range(24));
        return make_req(t, idx, rand_value(), nl);
    endfunction

    // Long receiver hold, counted in cycles, while the sender keeps offering.
    initial
    begin
        hold_rsp = 1'b0;
        wait (words_sent >= 324);
        hold_rsp = 1'b1;
        repeat (400) @(posedge clk);
        hold_rsp = 1'b0;
    end

    // Receiver: random stalls per word, plus the long hold.
    initial
    begin
        int wait_cycles;
        rsp_stall <= 1'b1;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = $urandom_range(16);
            if ($urandom_range(3) == 0) wait_cycles = 0;
            if (wait_cycles != 0 || hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
                while (hold_rsp) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
        end
    end

    // Response monitor.
    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall) sb.check_response(rsp);

    // Run time limit.
    initial
    begin
        #8000000;
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        int drain;
        sb = new();
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        words_sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-store errors, then extremes and every request code.
        send_request(make_req(REQ_POP, 8'd0, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_GET, 8'd0, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_SET, 8'hff, 32'hffff_ffff, 9'd0), 0);
        send_request(make_req(REQ_FIND, 8'd0, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_PUSH, 8'd0, 32'h7fff_ffff, 9'd0), 0);
        send_request(make_req(REQ_PUSH, 8'd0, 32'h8000_0000, 9'd0), 0);
        send_request(make_req(REQ_PUSH, 8'd0, 32'hffff_ffff, 9'd0), 0);
        send_request(make_req(REQ_PUSH, 8'd0, 32'h0000_0001, 9'd0), 0);
        send_request(make_req(REQ_SORT, 8'd0, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_GET, 8'd0, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_SET, 8'd3, 32'h5555_aaaa, 9'd0), 0);
        send_request(make_req(REQ_SET, 8'd4, 32'h1234_5678, 9'd0), 0);
        send_request(make_req(REQ_FIND, 8'd0, 32'h5555_aaaa, 9'd0), 0);
        send_request(make_req(REQ_FIND, 8'd0, 32'h0bad_0bad, 9'd0), 0);
        send_request(make_req(3'd7, 8'hff, 32'hffff_ffff, 9'h1ff), 0);
        send_request(make_req(REQ_RESIZE, 8'd0, 32'd0, 9'h1ff), 0);
        send_request(make_req(REQ_RESIZE, 8'd0, 32'd0, 9'd257), 0);
        send_request(make_req(REQ_RESIZE, 8'd0, 32'd0, 9'd256), 0);
        send_request(make_req(REQ_PUSH, 8'd0, 32'd9, 9'd0), 0);
        send_request(make_req(REQ_SET, 8'hff, 32'h8000_0000, 9'd0), 0);
        send_request(make_req(REQ_GET, 8'hff, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_FIND, 8'd0, 32'h8000_0000, 9'd0), 0);
        send_request(make_req(REQ_POP, 8'd0, 32'd0, 9'd0), 0);
        send_request(make_req(REQ_RESIZE, 8'd0, 32'd0, 9'd0), 0);

        // Random part; the receiver holds off once while requests keep coming,
        // and the sender pauses once until every response is in.
        for (int n = 0; n < 1880; n++)
        begin
            if (n == 900)
            begin
                req_valid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge clk);
            end
            send_request(rand_req(sb.depth), 0);
        end
        req_valid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < 2000000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

`default_nettype wire

>>> filelist.f
rtl/core/bias_pkg.sv
rtl/core/bias_mem.sv
rtl/core/bias_ctrl.sv
rtl/core/bounded_int_array_stack.sv
rtl/core/bias_checker.sv
tb/testbench.sv
